// ----- design/dltq_pkg.sv -----
// Shared types and constants for the delta list timer queue.
`default_nettype none
package dltq_pkg;
  localparam int QueueDepthDefault = 16;
  localparam int DelayBitsDefault  = 16;
  localparam int MaxResults        = 16;
  localparam int TaskBits          = 8;
  localparam int InDataBits        = 32;
  localparam int OutDataBits       = 16;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_TICK   = 2'd1,
    MODE_REMOVE = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NULL     = 3'd1,
    ST_BADDELAY = 3'd2,
    ST_FULL     = 3'd3,
    ST_NOTFOUND = 3'd4,
    ST_RELEASED = 3'd5,
    ST_NONE     = 3'd6
  } status_t;

  // Cell operation broadcast to every cell of the chain.
  typedef enum logic [2:0] {
    OP_HOLD  = 3'd0,
    OP_SHR   = 3'd1,  // make room at index pos, write new entry there
    OP_SHL   = 3'd2,  // close gap at index pos
    OP_DEC   = 3'd3,  // count head down
    OP_SUB   = 3'd4,  // subtract value from delta at pos
    OP_ADD   = 3'd5   // add value to delta at pos
  } cell_op_t;
endpackage
`default_nettype wire

// ----- design/dltq_cell.sv -----
// One slot of the delta list: holds an entry and trades it with neighbors.
`default_nettype none
module dltq_cell
  import dltq_pkg::*;
#(
  parameter int DelayBits = DelayBitsDefault,
  parameter int IdxBits   = 4
) (
  input  wire logic                 clk,
  input  wire cell_op_t             op,
  input  wire logic [IdxBits-1:0]   pos,
  input  wire logic [IdxBits-1:0]   self_idx,
  input  wire logic [DelayBits-1:0] value,
  input  wire logic [TaskBits-1:0]  new_task,
  input  wire logic                 new_waits,
  input  wire logic [TaskBits-1:0]  left_task,
  input  wire logic [DelayBits-1:0] left_delta,
  input  wire logic                 left_waits,
  input  wire logic [TaskBits-1:0]  right_task,
  input  wire logic [DelayBits-1:0] right_delta,
  input  wire logic                 right_waits,
  output logic      [TaskBits-1:0]  task_q,
  output logic      [DelayBits-1:0] delta_q,
  output logic                      waits_q
);
  always_ff @(posedge clk) begin
    unique case (op)
      OP_SHR: begin
        if (self_idx == pos) begin
          task_q  <= new_task;
          delta_q <= value;
          waits_q <= new_waits;
        end else if (self_idx > pos) begin
          task_q  <= left_task;
          delta_q <= left_delta;
          waits_q <= left_waits;
        end
      end
      OP_SHL: begin
        if (self_idx >= pos) begin
          task_q  <= right_task;
          delta_q <= right_delta;
          waits_q <= right_waits;
        end
      end
      OP_DEC: if (self_idx == '0) delta_q <= delta_q - 1'b1;
      OP_SUB: if (self_idx == pos) delta_q <= delta_q - value;
      OP_ADD: if (self_idx == pos) delta_q <= delta_q + value;
      default: ;
    endcase
  end
endmodule
`default_nettype wire

// ----- design/delta_list_timer_queue_core.sv -----
// Top level of the delta list timer queue: sequencer over a chain of cells.
// The queue is a row of QUEUE_DEPTH cells, slot 0 the head, each holding a
// task id, a delta and a timed-wait flag. A sequencer drives all cells with
// one shared operation per cycle; a shift moves every entry one cell at
// once. An insert or remove scans the list one entry a cycle; a tick counts
// the head down, then releases the leading tasks whose delta is zero, one at
// a time (up to 16 released per tick). Results leave through an output
// register, one item at a time; the next input item is taken once the last
// result of the current one has been handed off. Mode 3 gives no result.
`default_nettype none
module delta_list_timer_queue_core
  import dltq_pkg::*;
#(
  parameter int QUEUE_DEPTH = QueueDepthDefault,
  parameter int DELAY_BITS  = DelayBitsDefault
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  // mode[1:0], task_id[9:2], delay[25:10], timed_wait[26], zeros above
  input  wire logic [InDataBits-1:0]  s_tdata,
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  // status[2:0], released_task[10:3], timed_out[11], zeros above
  output logic [OutDataBits-1:0]      m_tdata,
  output logic                        m_tlast
);
  localparam int IdxBits = $clog2(QUEUE_DEPTH);
  localparam int CntBits = $clog2(QUEUE_DEPTH + 1);
  localparam int RelBits = $clog2(MaxResults + 1);
  localparam logic [DELAY_BITS-1:0] DelayMax = {DELAY_BITS{1'b1}};

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN_INS, S_FIX_INS, S_SCAN_REM, S_TICK, S_OUT
  } state_t;

  state_t                state;
  logic [CntBits-1:0]    count;
  logic [CntBits-1:0]    idx;
  logic [DELAY_BITS:0]   sum;
  logic [DELAY_BITS-1:0] dly;
  logic [TaskBits-1:0]   tid;
  logic                  tw;
  logic [RelBits-1:0]    nrel;
  logic                  tick_done;

  cell_op_t              op;
  logic [IdxBits-1:0]    pos;
  logic [DELAY_BITS-1:0] value;
  logic                  out_load;

  logic [TaskBits-1:0]   ctask  [QUEUE_DEPTH];
  logic [DELAY_BITS-1:0] cdelta [QUEUE_DEPTH];
  logic                  cwaits [QUEUE_DEPTH];

  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    localparam int L = (g == 0) ? 0 : g - 1;
    localparam int R = (g == QUEUE_DEPTH - 1) ? g : g + 1;
    dltq_cell #(.DelayBits(DELAY_BITS), .IdxBits(IdxBits)) u_cell (
      .clk, .op, .pos, .self_idx(IdxBits'(g)), .value,
      .new_task(tid), .new_waits(tw),
      .left_task(ctask[L]), .left_delta(cdelta[L]), .left_waits(cwaits[L]),
      .right_task(ctask[R]), .right_delta(cdelta[R]), .right_waits(cwaits[R]),
      .task_q(ctask[g]), .delta_q(cdelta[g]), .waits_q(cwaits[g])
    );
  end

  // Input fields.
  logic [1:0]            in_mode;
  logic [TaskBits-1:0]   in_tid;
  logic [15:0]           in_dly_raw;
  logic [DELAY_BITS-1:0] in_dly;
  assign in_mode    = s_tdata[1:0];
  assign in_tid     = s_tdata[9:2];
  assign in_dly_raw = s_tdata[25:10];
  always_comb begin
    // Saturate a delay that does not fit in DELAY_BITS.
    if (DELAY_BITS < 16 && (in_dly_raw >> DELAY_BITS) != '0) in_dly = DelayMax;
    else in_dly = DELAY_BITS'(in_dly_raw);
  end

  logic [IdxBits-1:0]    cur_idx;
  logic [DELAY_BITS:0]   sum_next;
  logic                  at_end;
  assign at_end   = (idx >= count);
  assign cur_idx  = idx[IdxBits-1:0];
  assign sum_next = sum + (DELAY_BITS+1)'(cdelta[cur_idx]);

  assign s_tready = (state == S_IDLE) && !m_tvalid;

  // Cell operation for this cycle.
  always_comb begin
    op    = OP_HOLD;
    pos   = cur_idx;
    value = '0;
    unique case (state)
      S_SCAN_INS: if (at_end || sum_next > {1'b0, dly}) begin
        op    = OP_SHR;
        value = dly - sum[DELAY_BITS-1:0];
      end
      S_FIX_INS: begin
        op    = OP_SUB;
        value = dly - sum[DELAY_BITS-1:0];
      end
      S_SCAN_REM: if (!at_end && ctask[cur_idx] == tid) begin
        op = OP_SHL;
      end
      S_TICK: begin
        pos = '0;
        if (!tick_done && count != '0 && cdelta[0] != '0) op = OP_DEC;
        else if (count != '0 && cdelta[0] == '0 && (!m_tvalid || m_tready)
                 && nrel < RelBits'(MaxResults)) op = OP_SHL;
      end
      default: ;
    endcase
  end

  // Load a new result into the output register this cycle.
  always_comb begin
    out_load = 1'b0;
    unique case (state)
      S_IDLE: out_load = s_tvalid && s_tready &&
                         (((in_mode == MODE_INSERT) &&
                           (in_tid == '0 || in_dly_raw == '0 ||
                            count == CntBits'(QUEUE_DEPTH))) ||
                          ((in_mode == MODE_REMOVE) && in_tid == '0));
      S_SCAN_REM: out_load = at_end;
      S_TICK: out_load = (op == OP_SHL) || (op != OP_DEC && !m_tvalid);
      S_OUT: out_load = 1'b1;
      default: ;
    endcase
  end

  logic [DELAY_BITS-1:0] rem_delta;
  assign rem_delta = cdelta[cur_idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      m_tvalid  <= 1'b0;
      m_tdata   <= '0;
      m_tlast   <= 1'b0;
      idx       <= '0;
      sum       <= '0;
      nrel      <= '0;
      tick_done <= 1'b0;
    end else begin
      m_tvalid <= out_load || (m_tvalid && !m_tready);
      unique case (state)
        S_IDLE: if (s_tvalid && s_tready) begin
          tid       <= in_tid;
          tw        <= s_tdata[26];
          dly       <= in_dly;
          idx       <= '0;
          sum       <= '0;
          nrel      <= '0;
          tick_done <= 1'b0;
          priority case (in_mode)
            MODE_INSERT: begin
              if (in_tid == '0) begin
                m_tlast  <= 1'b1;
                m_tdata  <= OutDataBits'(ST_NULL);
              end else if (in_dly_raw == '0) begin
                m_tlast  <= 1'b1;
                m_tdata  <= OutDataBits'(ST_BADDELAY);
              end else if (count == CntBits'(QUEUE_DEPTH)) begin
                m_tlast  <= 1'b1;
                m_tdata  <= OutDataBits'(ST_FULL);
              end else state <= S_SCAN_INS;
            end
            MODE_TICK: state <= S_TICK;
            MODE_REMOVE: begin
              if (in_tid == '0) begin
                m_tlast  <= 1'b1;
                m_tdata  <= OutDataBits'(ST_NULL);
              end else state <= S_SCAN_REM;
            end
            default: ;
          endcase
        end
        S_SCAN_INS: begin
          if (op == OP_SHR) begin
            count <= count + 1'b1;
            if (at_end) begin
              state <= S_OUT;
            end else begin
              idx   <= idx + 1'b1;
              state <= S_FIX_INS;
            end
          end else begin
            sum <= sum_next;
            idx <= idx + 1'b1;
          end
        end
        S_FIX_INS: state <= S_OUT;
        S_SCAN_REM: begin
          if (at_end) begin
            m_tlast  <= 1'b1;
            m_tdata  <= OutDataBits'(ST_NOTFOUND);
            state    <= S_IDLE;
          end else if (op == OP_SHL) begin
            count <= count - 1'b1;
            // Hand the removed delta on to the entry now at this index.
            sum   <= {1'b0, rem_delta};
            if ({1'b0, idx} + 1'b1 < (CntBits+1)'(count)) state <= S_FIX_INS;
            else state <= S_OUT;
            dly   <= '0;
          end else idx <= idx + 1'b1;
        end
        S_TICK: begin
          tick_done <= 1'b1;
          if (op == OP_DEC) begin
          end else if (op == OP_SHL) begin
            count    <= count - 1'b1;
            nrel     <= nrel + 1'b1;
            m_tdata  <= OutDataBits'({cwaits[0], ctask[0], ST_RELEASED});
            m_tlast  <= (count == CntBits'(1)) || (cdelta[1] != '0)
                        || (nrel + 1'b1 == RelBits'(MaxResults));
            if ((count == CntBits'(1)) || (cdelta[1] != '0)
                || (nrel + 1'b1 == RelBits'(MaxResults))) state <= S_IDLE;
          end else if (!m_tvalid) begin
            m_tlast  <= 1'b1;
            m_tdata  <= OutDataBits'(ST_NONE);
            state    <= S_IDLE;
          end
        end
        S_OUT: begin
          m_tlast  <= 1'b1;
          m_tdata  <= OutDataBits'(ST_OK);
          state    <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Remove reuses S_FIX_INS with dly = 0 and sum = removed delta: the
  // subtract then becomes an add of the removed delta.
  // (value = 0 - sum = -sum, so delta - value = delta + sum mod 2^bits.)

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CntBits'(QUEUE_DEPTH))
    else $error("entry count beyond depth");
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> state == S_IDLE)
    else $error("ready outside idle");
  a_tick_limit: assert property (@(posedge clk) disable iff (rst)
    nrel <= RelBits'(MaxResults))
    else $error("too many releases");
endmodule
`default_nettype wire

// ----- tb/tb_top.sv -----
// Testbench for the delta list timer queue: self-checking, predictor driven.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
  import dltq_pkg::*;

  localparam int Depth     = QueueDepthDefault;
  localparam int LimitCyc  = 2000000;

  typedef struct packed {
    status_t    status;
    logic [7:0] task_id;
    logic       timed_out;
    logic       last;
  } result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [InDataBits-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OutDataBits-1:0] m_tdata;
  logic m_tlast;

  always #2 clk = ~clk;

  delta_list_timer_queue_core u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  // Shadow copy of the sleep queue, slot 0 the head.
  logic [7:0]  q_task [Depth];
  logic [15:0] q_delta[Depth];
  logic        q_wait [Depth];
  int          q_count;

  result_t pending_results[$];
  int  mismatches;
  int  results_seen;
  int  released_seen;
  int  items_sent;
  longint cycles;
  bit  hold_off;   // receiver hold-off request
  bit  random_ready;

  // Keep the ids that are live so removes mostly hit.
  function automatic logic [7:0] pick_queued_id();
    if (q_count == 0) return 8'($urandom_range(1, 255));
    return q_task[$urandom_range(0, q_count - 1)];
  endfunction

  function automatic void push_result(status_t st, logic [7:0] id, logic to, logic lst);
    result_t r;
    r.status = st; r.task_id = id; r.timed_out = to; r.last = lst;
    pending_results.push_back(r);
  endfunction

  function automatic void drop_entry(int i);
    for (int j = i; j + 1 < q_count; j++) begin
      q_task[j] = q_task[j+1]; q_delta[j] = q_delta[j+1]; q_wait[j] = q_wait[j+1];
    end
    q_count--;
  endfunction

  // Work out the results of one accepted item and advance the shadow queue.
  function automatic void predict_queue(mode_t mode, logic [7:0] id, logic [15:0] dly,
                                        logic tw);
    int sum, pos, n;
    logic [15:0] d;
    sum = 0; pos = 0; n = 0;
    case (mode)
      MODE_INSERT: begin
        if (id == 0) push_result(ST_NULL, 0, 0, 1);
        else if (dly == 0) push_result(ST_BADDELAY, 0, 0, 1);
        else if (q_count >= Depth) push_result(ST_FULL, 0, 0, 1);
        else begin
          while (pos < q_count && sum + q_delta[pos] <= dly) begin
            sum += q_delta[pos]; pos++;
          end
          d = 16'(dly - sum);
          for (int j = q_count; j > pos; j--) begin
            q_task[j] = q_task[j-1]; q_delta[j] = q_delta[j-1]; q_wait[j] = q_wait[j-1];
          end
          q_task[pos] = id; q_delta[pos] = d; q_wait[pos] = tw;
          q_count++;
          if (pos + 1 < q_count) q_delta[pos+1] -= d;
          push_result(ST_OK, 0, 0, 1);
        end
      end
      MODE_TICK: begin
        if (q_count > 0 && q_delta[0] != 0) q_delta[0]--;
        while (q_count > 0 && q_delta[0] == 0 && n < MaxResults) begin
          push_result(ST_RELEASED, q_task[0], q_wait[0], 0);
          drop_entry(0);
          n++;
        end
        if (n == 0) push_result(ST_NONE, 0, 0, 1);
        else pending_results[$].last = 1'b1;
      end
      MODE_REMOVE: begin
        if (id == 0) push_result(ST_NULL, 0, 0, 1);
        else begin
          pos = -1;
          for (int i = 0; i < q_count; i++)
            if (pos < 0 && q_task[i] == id) pos = i;
          if (pos < 0) push_result(ST_NOTFOUND, 0, 0, 1);
          else begin
            // the entry behind takes over the removed delta, head included
            if (pos + 1 < q_count) q_delta[pos+1] += q_delta[pos];
            drop_entry(pos);
            push_result(ST_OK, 0, 0, 1);
          end
        end
      end
      default: ;  // mode 3: ignored, no result
    endcase
  endfunction

  // Offer one item, after a random gap when gaps is set; hold it until accepted.
  task automatic send_item(mode_t mode, logic [7:0] id, logic [15:0] dly, logic tw,
                           bit gaps = 1);
    int gap;
    gap = 0;
    if (gaps) gap = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40)
                  : ($urandom_range(0, 2) == 0 ? $urandom_range(1, 3) : 0);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {5'b0, tw, dly, id, mode};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_queue(mode, id, dly, tw);
    items_sent++;
  endtask

  task automatic idle_sender();
    s_tvalid <= 1'b0;
  endtask

  // Pause the sender until every expected result has come.
  task automatic drain();
    idle_sender();
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic send_random(int n, int insert_weight);
    int r;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < insert_weight)
        send_item(MODE_INSERT, ($urandom_range(0, 30) == 0) ? 8'd0 : 8'($urandom_range(1, 255)),
                  ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6)),
                  1'($urandom));
      else if (r < insert_weight + 30)
        send_item(MODE_TICK, 8'($urandom), 16'($urandom), 1'($urandom));
      else if (r < 97)
        send_item(MODE_REMOVE, ($urandom_range(0, 3) == 0) ? 8'($urandom) : pick_queued_id(),
                  16'($urandom), 1'($urandom));
      else
        send_item(MODE_NONE, 8'($urandom), 16'($urandom), 1'($urandom));
    end
  endtask

  // Field extremes, every mode and each named corner case.
  task automatic test_directed();
    send_item(MODE_TICK, 0, 0, 0);            // tick on empty queue
    send_item(MODE_REMOVE, 8'd5, 0, 0);       // remove on empty queue
    send_item(MODE_INSERT, 8'd0, 16'd5, 1);   // null task
    send_item(MODE_REMOVE, 8'd0, 0, 0);
    send_item(MODE_INSERT, 8'd9, 16'd0, 1);   // zero delay
    send_item(MODE_INSERT, 8'd255, 16'hFFFF, 1);
    send_item(MODE_INSERT, 8'd1, 16'd2, 0);
    send_item(MODE_INSERT, 8'd7, 16'd2, 1);   // equal wake times
    send_item(MODE_INSERT, 8'd7, 16'd3, 0);   // duplicate id
    send_item(MODE_REMOVE, 8'd1, 0, 0);       // remove head, delta passes on
    send_item(MODE_REMOVE, 8'd7, 0, 0);       // first match
    send_item(MODE_NONE, 8'hFF, 16'hFFFF, 1);
    send_item(MODE_TICK, 0, 0, 0);
    send_item(MODE_TICK, 0, 0, 0);
    send_item(MODE_TICK, 0, 0, 0);
    send_item(MODE_REMOVE, 8'd255, 0, 0);     // drop the long sleeper
    // fill the queue with equal delays so one tick releases all sixteen
    for (int i = 0; i < Depth; i++) send_item(MODE_INSERT, 8'(i + 20), 16'd1, 1'(i));
    send_item(MODE_INSERT, 8'd99, 16'd1, 0);  // full queue
    drain();
  endtask

  task automatic test_release_all();
    send_item(MODE_TICK, 0, 0, 0);
    while (q_count > 0) send_item(MODE_TICK, 0, 0, 0);
    drain();
  endtask

  // Receiver holds off while the sender keeps offering.
  task automatic test_backpressure();
    hold_off = 1'b1;
    for (int i = 0; i < 12; i++) send_item(MODE_INSERT, 8'($urandom_range(1, 255)),
                                           16'($urandom_range(1, 4)), 1'($urandom), 0);
    hold_off = 1'b0;
    drain();
  endtask

  task automatic test_random();
    send_random(180, 45);
    drain();
    random_ready = 1'b0;   // stretch with a receiver that never stalls
    send_random(60, 40);
    drain();
    random_ready = 1'b1;
    send_random(140, 35);
    drain();
    // empty the queue by removing the head, long sleepers included
    while (q_count > 0) send_item(MODE_REMOVE, q_task[0], 0, 0);
    drain();
  endtask

  // Receiver: random stalls, a counted hold-off when asked.
  initial begin
    int stall;
    random_ready = 1'b1;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_off) begin
        m_tready <= 1'b0;
        repeat (300) @(posedge clk);
      end
      if (random_ready && $urandom_range(0, 3) == 0) begin
        stall = ($urandom_range(0, 12) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
    end
  end

  // Check every accepted result against the oldest expectation.
  always @(posedge clk) begin
    result_t exp_r;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result data=%h last=%b", m_tdata, m_tlast);
      end else begin
        exp_r = pending_results.pop_front();
        if (exp_r.status == ST_RELEASED) released_seen++;
        if (m_tdata[2:0] !== exp_r.status || m_tdata[10:3] !== exp_r.task_id ||
            m_tdata[11] !== exp_r.timed_out || m_tdata[15:12] !== 4'b0 ||
            m_tlast !== exp_r.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp status=%0d task=%0d to=%b last=%b, got status=%0d task=%0d to=%b last=%b",
                     exp_r.status, exp_r.task_id, exp_r.timed_out, exp_r.last,
                     m_tdata[2:0], m_tdata[10:3], m_tdata[11], m_tlast);
        end
      end
    end
  end

  // Cycle limit.
  always @(posedge clk) begin
    cycles++;
    if (cycles > LimitCyc) begin
      $display("timeout with %0d results outstanding", pending_results.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    q_count = 0; mismatches = 0; results_seen = 0; released_seen = 0;
    items_sent = 0; cycles = 0; hold_off = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_release_all();
    test_backpressure();
    test_random();
    if (pending_results.size() != 0) mismatches++;
    $display("sent %0d items, checked %0d results (%0d releases)",
             items_sent, results_seen, released_seen);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
`default_nettype wire
